// ===== hw/rtl/mcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Monge chain DP engine: shared definitions
// Widths, memory depths, candidate entry layout, cost requests and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package mcd_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int START_W    = 41;
   localparam int DP_W       = 48;
   localparam int COST_W     = DP_W + 2;
   localparam int SQ_W       = 2 * COORD_BITS + 2;
   localparam int PT_W       = 3 * COORD_BITS;
   localparam int CAND_DEPTH = MAX_POINTS + 1;
   localparam int DP_DEPTH   = MAX_POINTS + 1;
   localparam int IDX_W      = $clog2(MAX_POINTS + 2);
   localparam int IDX1_W     = IDX_W + 1;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int DP_AW      = $clog2(DP_DEPTH);
   localparam int CAND_AW    = $clog2(CAND_DEPTH);

   localparam logic CSR_OBJECTIVE_MODE = 1'b0;
   localparam logic CSR_START_COST     = 1'b1;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [IDX1_W-1:0]        idx1_type;
   typedef logic signed [COST_W-1:0] cost_type;
   typedef logic signed [DP_W-1:0]   dp_type;

   typedef struct packed {
      idx_type k;
      idx_type lim;
   } cand_type;

   typedef struct packed {
      logic    start;
      idx_type k;
      idx_type r;
   } cost_req_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_MIN_INIT,
      ST_MIN_RD_BACK,
      ST_MIN_GOT_BACK,
      ST_MIN_DECIDE,
      ST_MIN_RD_FRONT,
      ST_MIN_GOT_FRONT,
      ST_MIN_POP,
      ST_MIN_CROSSED,
      ST_MIN_TRIM,
      ST_MIN_TRIM_CHK,
      ST_MIN_INC_WR,
      ST_MAX_INIT,
      ST_MAX_STEP,
      ST_MAX_GOT_BACK,
      ST_MAX_EMPTY,
      ST_MAX_DECIDE,
      ST_MAX_POP_RD,
      ST_MAX_POP_GOT,
      ST_MAX_POP,
      ST_MAX_CROSSED,
      ST_MAX_TAIL,
      ST_MAX_TAIL_CHK,
      ST_CP_START,
      ST_CP_CHECK,
      ST_CP_LOOP,
      ST_CP_STEP,
      ST_CMP_A,
      ST_CMP_WA,
      ST_CMP_B,
      ST_CMP_WB,
      ST_NEXT_J,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/mcd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mcd_cost_unit.sv =====
// ----------------------------------------------------------------------------
// Monge chain DP engine: cost unit
// Holds the point and DP memories and evaluates dp[k] + s*((a[r-1]-x[k])^2
// + y[k]^2) for one (k, r) pair; cost_done flags the registered result.
// ----------------------------------------------------------------------------
module mcd_cost_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  mcd_pkg::cost_req_type     cost_req,
   input  logic                      mode,
   input  mcd_pkg::idx_type          npts,
   input  logic                      pt_we,
   input  logic [mcd_pkg::PT_AW-1:0] pt_waddr,
   input  logic [mcd_pkg::PT_W-1:0]  pt_wdata,
   input  logic                      dp_we,
   input  logic [mcd_pkg::DP_AW-1:0] dp_waddr,
   input  mcd_pkg::dp_type           dp_wdata,
   output logic                      cost_done,
   output mcd_pkg::cost_type         cost
);

   localparam int CB = mcd_pkg::COORD_BITS;

   mcd_pkg::idx_type r_cl;
   mcd_pkg::idx_type k_pt;
   mcd_pkg::idx_type k_dp;
   mcd_pkg::idx_type a_idx;

   logic                      pt_re;
   logic [mcd_pkg::PT_AW-1:0] pt_raddr;
   logic [mcd_pkg::PT_W-1:0]  pt_rdata;
   logic [mcd_pkg::DP_W-1:0]  dp_rdata;

   logic s1_ff, s2_ff, s3_ff, s4_ff, done_ff;
   mcd_pkg::idx_type kpt_ff, kdp_ff;
   logic [CB-1:0]             a_ff;
   logic signed [CB:0]        d_ff;
   logic signed [CB:0]        d_in;
   logic [CB-1:0]             y_ff;
   mcd_pkg::dp_type           dpv_ff, dpv2_ff;
   logic signed [2*CB+1:0]    dsq_in;
   logic [2*CB+1:0]           dsq_ff;
   logic [2*CB-1:0]           ysq_ff;
   logic [mcd_pkg::SQ_W-1:0]  vsum;
   mcd_pkg::cost_type         dp_ext, v_ext, cost_in, cost_ff;

   // clamp the column into 1..n and the source into range
   always_comb begin
      r_cl = cost_req.r;
      if (cost_req.r == '0) begin
         r_cl = mcd_pkg::idx_type'(1);
      end else if (cost_req.r > npts) begin
         r_cl = npts;
      end
      k_pt  = (cost_req.k >= npts) ? npts - mcd_pkg::idx_type'(1) : cost_req.k;
      k_dp  = (cost_req.k > npts) ? npts : cost_req.k;
      a_idx = r_cl - mcd_pkg::idx_type'(1);
   end

   assign pt_re    = cost_req.start | s1_ff;
   assign pt_raddr = s1_ff ? kpt_ff[mcd_pkg::PT_AW-1:0] : a_idx[mcd_pkg::PT_AW-1:0];

   mcd_ram #(.WIDTH(mcd_pkg::PT_W), .DEPTH(mcd_pkg::MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_en   (pt_re),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   mcd_ram #(.WIDTH(mcd_pkg::DP_W), .DEPTH(mcd_pkg::DP_DEPTH)) u_dp_ram (
      .clock   (clock),
      .wr_en   (dp_we),
      .wr_addr (dp_waddr),
      .wr_data (dp_wdata),
      .rd_en   (s1_ff),
      .rd_addr (kdp_ff[mcd_pkg::DP_AW-1:0]),
      .rd_data (dp_rdata)
   );

   assign d_in   = $signed({1'b0, a_ff}) - $signed({1'b0, pt_rdata[2*CB-1 -: CB]});
   assign dsq_in = d_ff * d_ff;
   assign vsum   = mcd_pkg::SQ_W'(dsq_ff) + mcd_pkg::SQ_W'(ysq_ff);
   assign dp_ext = mcd_pkg::cost_type'(dpv2_ff);
   assign v_ext  = mcd_pkg::cost_type'({1'b0, vsum});
   assign cost_in = mode ? dp_ext - v_ext : dp_ext + v_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         s3_ff   <= 1'b0;
         s4_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= cost_req.start;
         s2_ff   <= s1_ff;
         s3_ff   <= s2_ff;
         s4_ff   <= s3_ff;
         done_ff <= s4_ff;
      end
      if (cost_req.start) begin
         kpt_ff <= k_pt;
         kdp_ff <= k_dp;
      end
      if (s1_ff) begin
         a_ff <= pt_rdata[mcd_pkg::PT_W-1 -: CB];
      end
      if (s2_ff) begin
         d_ff   <= d_in;
         y_ff   <= pt_rdata[CB-1:0];
         dpv_ff <= dp_rdata;
      end
      if (s3_ff) begin
         dsq_ff  <= dsq_in;
         ysq_ff  <= y_ff * y_ff;
         dpv2_ff <= dpv_ff;
      end
      if (s4_ff) begin
         cost_ff <= cost_in;
      end
   end

   assign cost_done = done_ff;
   assign cost      = cost_ff;

endmodule

// ===== hw/rtl/monge_chain_dp_engine_core.sv =====
// ----------------------------------------------------------------------------
// Monge chain DP engine
// Collects points and solves the 1D/1D chain recurrence with a candidate
// deque (minimise) or candidate stack (maximise), emitting dp[n].
// ----------------------------------------------------------------------------
// Points load at one transaction per cycle while the engine is idle; a point
// beyond 1024 is dropped and flagged. The point marked last starts the solve,
// during which req_stall is high. Every cost evaluation passes through one
// shared cost unit (two reads of the point memory, one DP read, a squaring
// stage); a comparison is two evaluations in turn. Each point costs one
// comparison against the back candidate, one per further candidate examined,
// and for a crossover one check plus about log2(n) more for the binary
// search. The result is held in an output register, so new points load
// while it waits to be taken.
// ----------------------------------------------------------------------------
module monge_chain_dp_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [mcd_pkg::START_W-1:0]        csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mcd_pkg::FIELD_W-1:0]        req_target_pos,
   input  logic [mcd_pkg::FIELD_W-1:0]        req_source_pos,
   input  logic [mcd_pkg::FIELD_W-1:0]        req_source_height,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mcd_pkg::DP_W-1:0]    rsp_best_total,
   output logic                               rsp_too_many_points
);

   localparam int CB = mcd_pkg::COORD_BITS;

   function automatic logic [mcd_pkg::CAND_AW-1:0] slot_addr(
      input mcd_pkg::idx_type base, input mcd_pkg::idx_type ofs);
      mcd_pkg::idx1_type sum;
      sum = mcd_pkg::idx1_type'(base) + mcd_pkg::idx1_type'(ofs);
      if (sum >= mcd_pkg::idx1_type'(mcd_pkg::CAND_DEPTH)) begin
         sum = sum - mcd_pkg::idx1_type'(mcd_pkg::CAND_DEPTH);
      end
      return sum[mcd_pkg::CAND_AW-1:0];
   endfunction

   mcd_pkg::state_type state_ff, state_in;
   mcd_pkg::state_type cmp_ret_ff, cmp_ret_in;
   mcd_pkg::state_type cp_ret_ff, cp_ret_in;

   mcd_pkg::idx_type ka_ff, ka_in, ra_ff, ra_in, kb_ff, kb_in, rb_ff, rb_in;
   mcd_pkg::cost_type cost_a_ff, cost_a_in, cost_b_ff, cost_b_in;
   mcd_pkg::idx_type j_ff, j_in, head_ff, head_in, tail_ff, tail_in;
   mcd_pkg::idx_type npts_ff, npts_in, count_ff, count_in;
   mcd_pkg::idx_type l_ff, l_in, ng_ff, ng_in, ok_ff, ok_in;
   mcd_pkg::idx_type cp_l_ff, cp_l_in, cp_k_ff, cp_k_in;
   logic ovf_ff, ovf_in, mode_ff, mode_in, found_ff, found_in;
   logic objective_mode_ff, objective_mode_in;
   logic signed [mcd_pkg::START_W-1:0] start_cost_ff, start_cost_in;
   mcd_pkg::dp_type last_dp_ff, last_dp_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   mcd_pkg::dp_type rsp_best_ff, rsp_best_in;

   logic                         cand_we, cand_re;
   logic [mcd_pkg::CAND_AW-1:0]  cand_waddr, cand_raddr;
   mcd_pkg::cand_type            cand_wdata, cand_rd;
   logic [2*mcd_pkg::IDX_W-1:0]  cand_rd_bits;

   mcd_pkg::cost_req_type        cost_req;
   logic                         cost_done;
   mcd_pkg::cost_type            cost;
   logic                         pt_we, dp_we;
   logic [mcd_pkg::PT_W-1:0]     pt_wdata;
   logic [mcd_pkg::DP_AW-1:0]    dp_waddr;
   mcd_pkg::dp_type              dp_wdata;

   logic a_le_b, a_lt_b, tail_zero, tail_ge2, tail_room, count_room;
   logic last_j, out_free, cp_more;
   mcd_pkg::idx_type j_m1, j_p1, n_p1, mid, head_dec, head_inc;
   mcd_pkg::idx1_type mid_sum;

   assign a_le_b     = cost_a_ff <= cost_b_ff;
   assign a_lt_b     = cost_a_ff < cost_b_ff;
   assign tail_zero  = tail_ff == '0;
   assign tail_ge2   = tail_ff >= mcd_pkg::idx_type'(2);
   assign tail_room  = tail_ff < mcd_pkg::idx_type'(mcd_pkg::CAND_DEPTH);
   assign count_room = count_ff < mcd_pkg::idx_type'(mcd_pkg::MAX_POINTS);
   assign last_j     = j_ff == npts_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cp_more    = mcd_pkg::idx1_type'(ok_ff) > (mcd_pkg::idx1_type'(ng_ff) + 1'b1);
   assign j_m1       = j_ff - mcd_pkg::idx_type'(1);
   assign j_p1       = j_ff + mcd_pkg::idx_type'(1);
   assign n_p1       = npts_ff + mcd_pkg::idx_type'(1);
   assign mid_sum    = mcd_pkg::idx1_type'(ok_ff) + mcd_pkg::idx1_type'(ng_ff);
   assign mid        = mid_sum[mcd_pkg::IDX_W:1];
   assign head_dec   = (head_ff == '0) ? mcd_pkg::idx_type'(mcd_pkg::CAND_DEPTH - 1)
                                       : head_ff - mcd_pkg::idx_type'(1);
   assign head_inc   = (head_ff == mcd_pkg::idx_type'(mcd_pkg::CAND_DEPTH - 1)) ? '0
                                       : head_ff + mcd_pkg::idx_type'(1);
   assign cand_rd    = mcd_pkg::cand_type'(cand_rd_bits);

   mcd_ram #(.WIDTH(2*mcd_pkg::IDX_W), .DEPTH(mcd_pkg::CAND_DEPTH)) u_cand_ram (
      .clock   (clock),
      .wr_en   (cand_we),
      .wr_addr (cand_waddr),
      .wr_data (cand_wdata),
      .rd_en   (cand_re),
      .rd_addr (cand_raddr),
      .rd_data (cand_rd_bits)
   );

   mcd_cost_unit u_cost (
      .clock     (clock),
      .reset     (reset),
      .cost_req  (cost_req),
      .mode      (mode_ff),
      .npts      (npts_ff),
      .pt_we     (pt_we),
      .pt_waddr  (count_ff[mcd_pkg::PT_AW-1:0]),
      .pt_wdata  (pt_wdata),
      .dp_we     (dp_we),
      .dp_waddr  (dp_waddr),
      .dp_wdata  (dp_wdata),
      .cost_done (cost_done),
      .cost      (cost)
   );

   assign pt_wdata = {req_target_pos[CB-1:0], req_source_pos[CB-1:0],
                      req_source_height[CB-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcd_pkg::ST_IDLE: begin
            if (req_valid && req_last_point) begin
               state_in = objective_mode_ff ? mcd_pkg::ST_MAX_INIT : mcd_pkg::ST_MIN_INIT;
            end
         end
         mcd_pkg::ST_MIN_INIT:      state_in = mcd_pkg::ST_MIN_RD_BACK;
         mcd_pkg::ST_MIN_RD_BACK:   state_in = mcd_pkg::ST_MIN_GOT_BACK;
         mcd_pkg::ST_MIN_GOT_BACK:  state_in = mcd_pkg::ST_CMP_A;
         mcd_pkg::ST_MIN_DECIDE: begin
            state_in = a_le_b ? mcd_pkg::ST_NEXT_J : mcd_pkg::ST_MIN_RD_FRONT;
         end
         mcd_pkg::ST_MIN_RD_FRONT: begin
            state_in = tail_zero ? mcd_pkg::ST_NEXT_J : mcd_pkg::ST_MIN_GOT_FRONT;
         end
         mcd_pkg::ST_MIN_GOT_FRONT: state_in = mcd_pkg::ST_CMP_A;
         mcd_pkg::ST_MIN_POP: begin
            state_in = a_le_b ? mcd_pkg::ST_MIN_RD_FRONT : mcd_pkg::ST_CP_START;
         end
         mcd_pkg::ST_MIN_CROSSED:   state_in = mcd_pkg::ST_MIN_TRIM;
         mcd_pkg::ST_MIN_TRIM: begin
            state_in = tail_ge2 ? mcd_pkg::ST_MIN_TRIM_CHK : mcd_pkg::ST_MIN_INC_WR;
         end
         mcd_pkg::ST_MIN_TRIM_CHK: begin
            state_in = (cand_rd.lim == j_p1) ? mcd_pkg::ST_NEXT_J : mcd_pkg::ST_MIN_INC_WR;
         end
         mcd_pkg::ST_MIN_INC_WR:    state_in = mcd_pkg::ST_NEXT_J;
         mcd_pkg::ST_MAX_INIT:      state_in = mcd_pkg::ST_MAX_STEP;
         mcd_pkg::ST_MAX_STEP: begin
            state_in = tail_zero ? mcd_pkg::ST_CMP_A : mcd_pkg::ST_MAX_GOT_BACK;
         end
         mcd_pkg::ST_MAX_GOT_BACK:  state_in = mcd_pkg::ST_CMP_A;
         mcd_pkg::ST_MAX_EMPTY:     state_in = mcd_pkg::ST_MAX_TAIL;
         mcd_pkg::ST_MAX_DECIDE: begin
            state_in = a_lt_b ? mcd_pkg::ST_MAX_POP_RD : mcd_pkg::ST_MAX_TAIL;
         end
         mcd_pkg::ST_MAX_POP_RD: begin
            state_in = tail_zero ? mcd_pkg::ST_MAX_TAIL : mcd_pkg::ST_MAX_POP_GOT;
         end
         mcd_pkg::ST_MAX_POP_GOT:   state_in = mcd_pkg::ST_CMP_A;
         mcd_pkg::ST_MAX_POP: begin
            state_in = a_lt_b ? mcd_pkg::ST_MAX_POP_RD : mcd_pkg::ST_CP_START;
         end
         mcd_pkg::ST_MAX_CROSSED:   state_in = mcd_pkg::ST_MAX_TAIL;
         mcd_pkg::ST_MAX_TAIL: begin
            state_in = tail_zero ? mcd_pkg::ST_NEXT_J : mcd_pkg::ST_MAX_TAIL_CHK;
         end
         mcd_pkg::ST_MAX_TAIL_CHK:  state_in = mcd_pkg::ST_NEXT_J;
         mcd_pkg::ST_CP_START:      state_in = mcd_pkg::ST_CMP_A;
         mcd_pkg::ST_CP_CHECK: begin
            state_in = a_le_b ? mcd_pkg::ST_CP_LOOP : cp_ret_ff;
         end
         mcd_pkg::ST_CP_LOOP: begin
            state_in = cp_more ? mcd_pkg::ST_CMP_A : cp_ret_ff;
         end
         mcd_pkg::ST_CP_STEP:       state_in = mcd_pkg::ST_CP_LOOP;
         mcd_pkg::ST_CMP_A:         state_in = mcd_pkg::ST_CMP_WA;
         mcd_pkg::ST_CMP_WA: begin
            if (cost_done) begin
               state_in = mcd_pkg::ST_CMP_B;
            end
         end
         mcd_pkg::ST_CMP_B:         state_in = mcd_pkg::ST_CMP_WB;
         mcd_pkg::ST_CMP_WB: begin
            if (cost_done) begin
               state_in = cmp_ret_ff;
            end
         end
         mcd_pkg::ST_NEXT_J: begin
            if (last_j) begin
               state_in = mcd_pkg::ST_DONE;
            end else begin
               state_in = mode_ff ? mcd_pkg::ST_MAX_STEP : mcd_pkg::ST_MIN_RD_BACK;
            end
         end
         mcd_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mcd_pkg::ST_IDLE;
            end
         end
         default: state_in = mcd_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmp_ret_in        = cmp_ret_ff;
      cp_ret_in         = cp_ret_ff;
      ka_in             = ka_ff;
      ra_in             = ra_ff;
      kb_in             = kb_ff;
      rb_in             = rb_ff;
      cost_a_in         = cost_a_ff;
      cost_b_in         = cost_b_ff;
      j_in              = j_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      npts_in           = npts_ff;
      count_in          = count_ff;
      l_in              = l_ff;
      ng_in             = ng_ff;
      ok_in             = ok_ff;
      cp_l_in           = cp_l_ff;
      cp_k_in           = cp_k_ff;
      ovf_in            = ovf_ff;
      mode_in           = mode_ff;
      found_in          = found_ff;
      objective_mode_in = objective_mode_ff;
      start_cost_in     = start_cost_ff;
      last_dp_in        = last_dp_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_best_in       = rsp_best_ff;
      rsp_ovf_in        = rsp_ovf_ff;
      cand_we           = 1'b0;
      cand_waddr        = slot_addr(head_ff, tail_ff);
      cand_wdata        = '{k: j_m1, lim: n_p1};
      cand_re           = 1'b0;
      cand_raddr        = slot_addr(head_ff, tail_ff - mcd_pkg::idx_type'(1));
      cost_req          = '{start: 1'b0, k: ka_ff, r: ra_ff};
      pt_we             = 1'b0;
      dp_we             = 1'b0;
      dp_waddr          = j_ff[mcd_pkg::DP_AW-1:0];
      dp_wdata          = cost_a_ff[mcd_pkg::DP_W-1:0];

      if (csr_write_enable) begin
         case (csr_index)
            mcd_pkg::CSR_OBJECTIVE_MODE: objective_mode_in = csr_write_data[0];
            mcd_pkg::CSR_START_COST:     start_cost_in     = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         mcd_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (count_room) begin
                  pt_we    = 1'b1;
                  count_in = count_ff + mcd_pkg::idx_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_point) begin
                  npts_in    = count_room ? count_ff + mcd_pkg::idx_type'(1) : count_ff;
                  mode_in    = objective_mode_ff;
                  dp_we      = 1'b1;
                  dp_waddr   = '0;
                  dp_wdata   = mcd_pkg::dp_type'(start_cost_ff);
                  last_dp_in = mcd_pkg::dp_type'(start_cost_ff);
                  j_in       = mcd_pkg::idx_type'(1);
               end
            end
         end
         mcd_pkg::ST_MIN_INIT: begin
            head_in    = '0;
            tail_in    = mcd_pkg::idx_type'(1);
            cand_we    = 1'b1;
            cand_waddr = '0;
            cand_wdata = '{k: '0, lim: mcd_pkg::idx_type'(1)};
         end
         mcd_pkg::ST_MIN_RD_BACK: begin
            cand_re = 1'b1;
         end
         mcd_pkg::ST_MIN_GOT_BACK: begin
            l_in       = cand_rd.k;
            ka_in      = j_m1;
            ra_in      = j_ff;
            kb_in      = cand_rd.k;
            rb_in      = j_ff;
            cmp_ret_in = mcd_pkg::ST_MIN_DECIDE;
         end
         mcd_pkg::ST_MIN_DECIDE: begin
            dp_we = 1'b1;
            if (a_le_b) begin
               // new candidate beats the back: it alone remains
               last_dp_in = cost_a_ff[mcd_pkg::DP_W-1:0];
               head_in    = '0;
               tail_in    = mcd_pkg::idx_type'(1);
               cand_we    = 1'b1;
               cand_waddr = '0;
               cand_wdata = '{k: j_m1, lim: j_p1};
            end else begin
               dp_wdata   = cost_b_ff[mcd_pkg::DP_W-1:0];
               last_dp_in = cost_b_ff[mcd_pkg::DP_W-1:0];
            end
         end
         mcd_pkg::ST_MIN_RD_FRONT: begin
            if (tail_zero) begin
               tail_in    = mcd_pkg::idx_type'(1);
               cand_we    = 1'b1;
               cand_waddr = head_ff[mcd_pkg::CAND_AW-1:0];
               cand_wdata = '{k: j_m1, lim: j_p1};
            end else begin
               cand_re    = 1'b1;
               cand_raddr = head_ff[mcd_pkg::CAND_AW-1:0];
            end
         end
         mcd_pkg::ST_MIN_GOT_FRONT: begin
            l_in       = cand_rd.k;
            ka_in      = j_m1;
            ra_in      = cand_rd.lim;
            kb_in      = cand_rd.k;
            rb_in      = cand_rd.lim;
            cmp_ret_in = mcd_pkg::ST_MIN_POP;
         end
         mcd_pkg::ST_MIN_POP: begin
            if (a_le_b) begin
               head_in = head_inc;
               tail_in = tail_ff - mcd_pkg::idx_type'(1);
            end else begin
               cp_l_in   = j_m1;
               cp_k_in   = l_ff;
               cp_ret_in = mcd_pkg::ST_MIN_CROSSED;
            end
         end
         mcd_pkg::ST_MIN_CROSSED: begin
            if (found_ff && tail_room) begin
               head_in    = head_dec;
               tail_in    = tail_ff + mcd_pkg::idx_type'(1);
               cand_we    = 1'b1;
               cand_waddr = head_dec[mcd_pkg::CAND_AW-1:0];
               cand_wdata = '{k: j_m1, lim: ok_ff};
            end
         end
         mcd_pkg::ST_MIN_TRIM: begin
            cand_re = 1'b1;
            if (tail_ge2) begin
               cand_raddr = slot_addr(head_ff, tail_ff - mcd_pkg::idx_type'(2));
            end
         end
         mcd_pkg::ST_MIN_TRIM_CHK: begin
            if (cand_rd.lim == j_p1) begin
               tail_in = tail_ff - mcd_pkg::idx_type'(1);
            end else begin
               cand_re = 1'b1;
            end
         end
         mcd_pkg::ST_MIN_INC_WR: begin
            cand_we    = 1'b1;
            cand_waddr = slot_addr(head_ff, tail_ff - mcd_pkg::idx_type'(1));
            cand_wdata = '{k: cand_rd.k, lim: cand_rd.lim + mcd_pkg::idx_type'(1)};
         end
         mcd_pkg::ST_MAX_INIT: begin
            head_in    = '0;
            tail_in    = mcd_pkg::idx_type'(1);
            cand_we    = 1'b1;
            cand_waddr = '0;
            cand_wdata = '{k: '0, lim: n_p1};
         end
         mcd_pkg::ST_MAX_STEP: begin
            if (tail_zero) begin
               // stack empty: only the newest source counts
               ka_in      = j_m1;
               ra_in      = j_ff;
               kb_in      = j_m1;
               rb_in      = j_ff;
               cmp_ret_in = mcd_pkg::ST_MAX_EMPTY;
            end else begin
               cand_re = 1'b1;
            end
         end
         mcd_pkg::ST_MAX_GOT_BACK: begin
            l_in       = cand_rd.k;
            ka_in      = j_m1;
            ra_in      = j_ff;
            kb_in      = cand_rd.k;
            rb_in      = j_ff;
            cmp_ret_in = mcd_pkg::ST_MAX_DECIDE;
         end
         mcd_pkg::ST_MAX_EMPTY: begin
            dp_we      = 1'b1;
            last_dp_in = cost_a_ff[mcd_pkg::DP_W-1:0];
            if (tail_room) begin
               cand_we = 1'b1;
               tail_in = tail_ff + mcd_pkg::idx_type'(1);
            end
         end
         mcd_pkg::ST_MAX_DECIDE: begin
            dp_we = 1'b1;
            if (a_lt_b) begin
               last_dp_in = cost_a_ff[mcd_pkg::DP_W-1:0];
            end else begin
               dp_wdata   = cost_b_ff[mcd_pkg::DP_W-1:0];
               last_dp_in = cost_b_ff[mcd_pkg::DP_W-1:0];
            end
         end
         mcd_pkg::ST_MAX_POP_RD: begin
            if (tail_zero) begin
               cand_we = 1'b1;
               tail_in = tail_ff + mcd_pkg::idx_type'(1);
            end else begin
               cand_re = 1'b1;
            end
         end
         mcd_pkg::ST_MAX_POP_GOT: begin
            l_in       = cand_rd.k;
            ka_in      = j_m1;
            ra_in      = cand_rd.lim - mcd_pkg::idx_type'(1);
            kb_in      = cand_rd.k;
            rb_in      = cand_rd.lim - mcd_pkg::idx_type'(1);
            cmp_ret_in = mcd_pkg::ST_MAX_POP;
         end
         mcd_pkg::ST_MAX_POP: begin
            if (a_lt_b) begin
               tail_in = tail_ff - mcd_pkg::idx_type'(1);
            end else begin
               cp_l_in   = l_ff;
               cp_k_in   = j_m1;
               cp_ret_in = mcd_pkg::ST_MAX_CROSSED;
            end
         end
         mcd_pkg::ST_MAX_CROSSED: begin
            if (tail_room) begin
               cand_we    = 1'b1;
               cand_wdata = '{k: j_m1, lim: found_ff ? ok_ff : n_p1};
               tail_in    = tail_ff + mcd_pkg::idx_type'(1);
            end
         end
         mcd_pkg::ST_MAX_TAIL: begin
            cand_re = !tail_zero;
         end
         mcd_pkg::ST_MAX_TAIL_CHK: begin
            if (cand_rd.lim == j_p1) begin
               tail_in = tail_ff - mcd_pkg::idx_type'(1);
            end
         end
         mcd_pkg::ST_CP_START: begin
            ka_in      = cp_l_ff;
            ra_in      = npts_ff;
            kb_in      = cp_k_ff;
            rb_in      = npts_ff;
            cmp_ret_in = mcd_pkg::ST_CP_CHECK;
         end
         mcd_pkg::ST_CP_CHECK: begin
            found_in = 1'b0;
            ng_in    = j_m1;
            ok_in    = npts_ff;
         end
         mcd_pkg::ST_CP_LOOP: begin
            if (cp_more) begin
               ka_in      = cp_l_ff;
               ra_in      = mid;
               kb_in      = cp_k_ff;
               rb_in      = mid;
               cmp_ret_in = mcd_pkg::ST_CP_STEP;
            end else begin
               found_in = 1'b1;
            end
         end
         mcd_pkg::ST_CP_STEP: begin
            if (a_le_b) begin
               ok_in = ra_ff;
            end else begin
               ng_in = ra_ff;
            end
         end
         mcd_pkg::ST_CMP_A: begin
            cost_req = '{start: 1'b1, k: ka_ff, r: ra_ff};
         end
         mcd_pkg::ST_CMP_WA: begin
            if (cost_done) begin
               cost_a_in = cost;
            end
         end
         mcd_pkg::ST_CMP_B: begin
            cost_req = '{start: 1'b1, k: kb_ff, r: rb_ff};
         end
         mcd_pkg::ST_CMP_WB: begin
            if (cost_done) begin
               cost_b_in = cost;
            end
         end
         mcd_pkg::ST_NEXT_J: begin
            if (!last_j) begin
               j_in = j_p1;
            end
         end
         mcd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = mode_ff ? -last_dp_ff : last_dp_ff;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= mcd_pkg::ST_IDLE;
         head_ff           <= '0;
         tail_ff           <= '0;
         count_ff          <= '0;
         npts_ff           <= mcd_pkg::idx_type'(1);
         ovf_ff            <= 1'b0;
         mode_ff           <= 1'b0;
         objective_mode_ff <= 1'b0;
         start_cost_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         head_ff           <= head_in;
         tail_ff           <= tail_in;
         count_ff          <= count_in;
         npts_ff           <= npts_in;
         ovf_ff            <= ovf_in;
         mode_ff           <= mode_in;
         objective_mode_ff <= objective_mode_in;
         start_cost_ff     <= start_cost_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      cmp_ret_ff  <= cmp_ret_in;
      cp_ret_ff   <= cp_ret_in;
      ka_ff       <= ka_in;
      ra_ff       <= ra_in;
      kb_ff       <= kb_in;
      rb_ff       <= rb_in;
      cost_a_ff   <= cost_a_in;
      cost_b_ff   <= cost_b_in;
      j_ff        <= j_in;
      l_ff        <= l_in;
      ng_ff       <= ng_in;
      ok_ff       <= ok_in;
      cp_l_ff     <= cp_l_in;
      cp_k_ff     <= cp_k_in;
      found_ff    <= found_in;
      last_dp_ff  <= last_dp_in;
      rsp_best_ff <= rsp_best_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_stall           = state_ff != mcd_pkg::ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_total      = rsp_best_ff;
   assign rsp_too_many_points = rsp_ovf_ff;

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= mcd_pkg::idx_type'(mcd_pkg::CAND_DEPTH))
      else $error("candidate count beyond capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff < mcd_pkg::idx_type'(mcd_pkg::CAND_DEPTH))
      else $error("candidate head out of range");

   a_cost_owner: assert property (@(posedge clock) disable iff (reset)
      cost_done |-> (state_ff == mcd_pkg::ST_CMP_WA || state_ff == mcd_pkg::ST_CMP_WB))
      else $error("cost result with no comparison waiting");

   a_solve_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcd_pkg::ST_IDLE && req_valid && req_last_point) |=>
      (state_ff == mcd_pkg::ST_MIN_INIT || state_ff == mcd_pkg::ST_MAX_INIT))
      else $error("last point did not start a solve");

endmodule
